### rtl/rgf_pkg.sv
// ----------------------------------------------------------------------------
// rgf_pkg
// Shared types and constants of the radial gradient factor unit.
// ----------------------------------------------------------------------------
package rgf_pkg;

  localparam int unsigned CoordFracBits = 16;

  typedef logic [2:0] cfg_addr_t;

  localparam cfg_addr_t REG_PERIOD     = 3'd0;
  localparam cfg_addr_t REG_RING_COUNT = 3'd1;
  localparam cfg_addr_t REG_CYCLE_OFS  = 3'd2;
  localparam cfg_addr_t REG_INNER_FRAC = 3'd3;
  localparam cfg_addr_t REG_CURVE_TYPE = 3'd4;

  typedef enum logic [1:0] {
    CURVE_LINEAR   = 2'd0,
    CURVE_EASE_IN  = 2'd1,
    CURVE_EASE_OUT = 2'd2,
    CURVE_SMOOTH   = 2'd3
  } curve_e;

  localparam logic [30:0] PeriodReset = 31'(100 << CoordFracBits);
  localparam logic [15:0] RingReset   = 16'd256;
  localparam logic [16:0] OneQ16      = 17'h10000;
  localparam logic [17:0] ThreeQ16    = 18'h30000;

  localparam int unsigned RootW = 33;  // radius bits
  localparam int unsigned SumW  = 2 * RootW;

endpackage

### rtl/rgf_sqrt.sv
// ----------------------------------------------------------------------------
// rgf_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rgf_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rgf_pkg::SumW-1:0]      rad_i,
  output logic                          valid_o,
  output logic [rgf_pkg::RootW-1:0]     root_o
);

  localparam int unsigned RW  = rgf_pkg::RootW;
  localparam int unsigned RmW = RW + 3;
  localparam int unsigned SW  = rgf_pkg::SumW;

  logic [RmW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SW-1:0]  rad_q  [RW];
  logic [RW-1:0]  vld_q;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RmW-1:0] rem_p, shifted, trial, rem_d;
    logic [RW-1:0]  root_p, root_d;
    logic [SW-1:0]  rad_p, rad_d;
    logic           vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    always_comb begin
      shifted = {rem_p[RmW-3:0], rad_p[SW-1 -: 2]};
      trial   = RmW'({root_p, 2'b01});
      ge      = (shifted >= trial);
      rem_d   = ge ? (shifted - trial) : shifted;
      root_d  = {root_p[RW-2:0], ge};
      rad_d   = {rad_p[SW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_d;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

### rtl/rgf_div_pipe.sv
// ----------------------------------------------------------------------------
// rgf_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rgf_div_pipe #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] rem_i,      // partial remainder, below divisor
  input  logic [VW-1:0] divisor_i,  // held steady while items are in flight
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic [VW-1:0] rem_q  [DW];
  logic [DW-1:0] dvd_q  [DW];
  logic [DW-1:0] quot_q [DW];
  logic [SW-1:0] side_q [DW];
  logic [DW-1:0] vld_q;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_p, rem_d;
    logic [DW-1:0] dvd_p, dvd_d, quot_p, quot_d;
    logic [SW-1:0] side_p;
    logic [VW:0]   trial, dsub;
    logic          vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = rem_i;
      assign dvd_p  = dividend_i;
      assign quot_p = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign dvd_p  = dvd_q[k-1];
      assign quot_p = quot_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    always_comb begin
      trial  = {rem_p, dvd_p[DW-1]};
      ge     = (trial >= {1'b0, divisor_i});
      dsub   = trial - {1'b0, divisor_i};
      rem_d  = ge ? dsub[VW-1:0] : trial[VW-1:0];
      dvd_d  = DW'({dvd_p, 1'b0});
      quot_d = DW'({quot_p, ge});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dvd_q[k]  <= dvd_d;
        quot_q[k] <= quot_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[DW-1];
  assign quot_o  = quot_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

### rtl/radial_gradient_factor_unit.sv
// ----------------------------------------------------------------------------
// radial_gradient_factor_unit
// Blend factor of a repeating radial gradient with easing curves.
// ----------------------------------------------------------------------------
// Takes one position per clock and returns one Q1.16 factor per position,
// in order. The digit pipelines are 33 stages of square root, 35 stages
// of ring modulo, 16 stages for the ring phase and 17 for the
// inner-fraction rescale, set between the magnitude, squaring, sum, ring
// test, fix-up, inner cut, squares and curve stages. A stall on the output
// holds the whole pipeline; no transaction is lost or repeated.
module radial_gradient_factor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] pos_x, [63:32] pos_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] factor, [23:17] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned RW = rgf_pkg::RootW;

  // configuration
  logic [30:0]           period_q;
  logic [15:0]           ring_q;
  logic [31:0]           offset_q;
  logic [15:0]           inner_q;
  rgf_pkg::curve_e       curve_q;
  logic [46:0]           limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rgf_pkg::PeriodReset;
      ring_q   <= rgf_pkg::RingReset;
      offset_q <= '0;
      inner_q  <= '0;
      curve_q  <= rgf_pkg::CURVE_LINEAR;
      limit_q  <= 47'(rgf_pkg::PeriodReset) * 47'(rgf_pkg::RingReset);
    end else begin
      limit_q <= 47'(period_q) * 47'(ring_q);
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          rgf_pkg::REG_PERIOD:     period_q <= cfg_data_i[30:0];
          rgf_pkg::REG_RING_COUNT: ring_q   <= cfg_data_i[15:0];
          rgf_pkg::REG_CYCLE_OFS:  offset_q <= cfg_data_i;
          rgf_pkg::REG_INNER_FRAC: inner_q  <= cfg_data_i[15:0];
          rgf_pkg::REG_CURVE_TYPE: curve_q  <= rgf_pkg::curve_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
    end
  end

  // pipeline enable
  logic en;
  logic out_vld_q;
  logic [16:0] out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // S0 magnitudes, S1 squares, S2 sum
  logic        v0_q, v1_q, v2_q;
  logic [31:0] ax_q, ay_q;
  logic [63:0] sqx_q, sqy_q;
  logic [64:0] sum_q;
  logic [31:0] px, py;

  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= px[31] ? (~px + 32'd1) : px;
      ay_q  <= py[31] ? (~py + 32'd1) : py;
      sqx_q <= 64'(ax_q) * 64'(ax_q);
      sqy_q <= 64'(ay_q) * 64'(ay_q);
      sum_q <= 65'(sqx_q) + 65'(sqy_q);
    end
  end

  // radius
  logic          rad_vld;
  logic [RW-1:0] radius;

  rgf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (rgf_pkg::SumW'(sum_q)),
    .valid_o (rad_vld),
    .root_o  (radius)
  );

  // S3 ring test and phase sum
  logic        v3_q, neg3_q, in3_q;
  logic [34:0] u3_q;
  logic [34:0] phase;

  assign phase = {2'b00, radius} + {{3{offset_q[31]}}, offset_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      in3_q  <= (47'({radius, 8'h00}) < limit_q);
      neg3_q <= phase[34];
      u3_q   <= phase[34] ? (~phase + 35'd1) : phase;
    end
  end

  // ring modulo
  logic        mod_vld;
  logic [34:0] mod_quot;
  logic [30:0] mod_rem;
  logic [1:0]  mod_side;

  rgf_div_pipe #(.DW(35), .VW(31), .SW(2)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (u3_q),
    .rem_i      ('0),
    .divisor_i  (period_q),
    .side_i     ({neg3_q, in3_q}),
    .valid_o    (mod_vld),
    .quot_o     (mod_quot),
    .rem_o      (mod_rem),
    .side_o     (mod_side)
  );

  // S4 floor modulo fix-up
  logic        v4_q, in4_q;
  logic [30:0] m4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in4_q <= mod_side[0];
      m4_q  <= (mod_side[1] && mod_rem != '0) ? (period_q - mod_rem) : mod_rem;
    end
  end

  // ring phase m * 2^16 / period
  logic        ph_vld;
  logic [15:0] ph_quot;
  logic [30:0] ph_rem;
  logic        ph_in;

  rgf_div_pipe #(.DW(16), .VW(31), .SW(1)) u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v4_q),
    .dividend_i ('0),
    .rem_i      (m4_q),
    .divisor_i  (period_q),
    .side_i     (in4_q),
    .valid_o    (ph_vld),
    .quot_o     (ph_quot),
    .rem_o      (ph_rem),
    .side_o     (ph_in)
  );

  // S5 inner fraction cut
  logic        v5_q, gt5_q;
  logic [16:0] a5_q;
  logic [16:0] t5;

  assign t5 = ph_in ? {1'b0, ph_quot} : rgf_pkg::OneQ16;

  always_ff @(posedge clk_i) begin
    if (en) begin
      gt5_q <= (t5 > {1'b0, inner_q});
      a5_q  <= (t5 > {1'b0, inner_q}) ? (t5 - {1'b0, inner_q}) : '0;
    end
  end

  // rescale (t - inner) * 2^16 / (1 - inner); remainder starts at a/2
  logic        rs_vld;
  logic [16:0] rs_quot;
  logic [16:0] rs_rem;
  logic        rs_gt;

  rgf_div_pipe #(.DW(17), .VW(17), .SW(1)) u_rescale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v5_q),
    .dividend_i ({a5_q[0], 16'h0000}),
    .rem_i      ({1'b0, a5_q[16:1]}),
    .divisor_i  (rgf_pkg::OneQ16 - {1'b0, inner_q}),
    .side_i     (gt5_q),
    .valid_o    (rs_vld),
    .quot_o     (rs_quot),
    .rem_o      (rs_rem),
    .side_o     (rs_gt)
  );

  // S6 squares
  logic        v6_q;
  logic [16:0] t6_q, sq6_q, isq6_q;
  logic [16:0] t6, inv6;
  logic [33:0] sq_full, isq_full;

  always_comb begin
    t6       = rs_gt ? rs_quot : '0;
    inv6     = rgf_pkg::OneQ16 - t6;
    sq_full  = 34'(t6) * 34'(t6);
    isq_full = 34'(inv6) * 34'(inv6);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t6_q   <= t6;
      sq6_q  <= sq_full[32:16];
      isq6_q <= isq_full[32:16];
    end
  end

  // S7 curve and saturation
  logic [17:0] smooth_k;
  logic [34:0] smooth_p;
  logic [18:0] f7;

  always_comb begin
    smooth_k = rgf_pkg::ThreeQ16 - {t6_q, 1'b0};
    smooth_p = 35'(smooth_k) * 35'(sq6_q);
    case (curve_q)
      rgf_pkg::CURVE_LINEAR:   f7 = 19'(t6_q);
      rgf_pkg::CURVE_EASE_IN:  f7 = 19'(sq6_q);
      rgf_pkg::CURVE_EASE_OUT: f7 = 19'(rgf_pkg::OneQ16 - isq6_q);
      default:                 f7 = smooth_p[34:16];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= (f7 > 19'(rgf_pkg::OneQ16)) ? rgf_pkg::OneQ16 : f7[16:0];
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v0_q      <= s_axis_tvalid;
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      v3_q      <= rad_vld;
      v4_q      <= mod_vld;
      v5_q      <= ph_vld;
      v6_q      <= rs_vld;
      out_vld_q <= v6_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_q};

  // ring modulo quotient and final remainders are not needed downstream
  logic unused;
  assign unused = ^{mod_quot, ph_rem, rs_rem};

  // checks
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= rgf_pkg::OneQ16))
    else $error("factor above one");

  a_empty_rings: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && $past(limit_q) == '0 && $stable(limit_q)) |-> !in3_q)
    else $error("pixel inside an empty ring region");

  a_cut_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !gt5_q) |-> (a5_q == '0))
    else $error("inner cut left a nonzero remainder");

endmodule
